[sv/sgc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgc_pkg: shared constants of the segmented gamma curve unit
// Command codes, field widths, rounding constants and the breakpoint list
// at 10-bit scale.
// ----------------------------------------------------------------------------
package sgc_pkg;

    localparam int CH_W     = 2;
    localparam int SEG_IDX_W = 4;
    localparam int COEF_W   = 10;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam int UNITY_SHIFT = 6;
    localparam int ROUND_HALF  = 32;

    localparam int BP_COUNT = 15;
    localparam int BP_BITS  = 10;

    localparam logic [BP_BITS-1:0] BREAKPOINTS [BP_COUNT] = '{
        10'd0,   10'd16,  10'd32,  10'd64,  10'd96,  10'd128, 10'd192, 10'd256,
        10'd320, 10'd384, 10'd512, 10'd640, 10'd768, 10'd896, 10'd1023
    };

endpackage

[sv/sgc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgc_in_if: command and pixel channel
// Carries one write or one pixel per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sgc_in_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [sgc_pkg::CH_W-1:0]         channel;
    logic [sgc_pkg::SEG_IDX_W-1:0]    segment_index;
    logic [sgc_pkg::COEF_W-1:0]       offset_value;
    logic [sgc_pkg::COEF_W-1:0]       slope_value;
    logic [SAMPLE_BITS-1:0]           pixel_in;

    modport source (
        output valid, cmd, channel, segment_index, offset_value, slope_value, pixel_in,
        input  ready
    );
    modport sink (
        input  valid, cmd, channel, segment_index, offset_value, slope_value, pixel_in,
        output ready
    );
endinterface

[sv/sgc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgc_out_if: corrected pixel channel
// Carries one corrected component and its channel per beat.
// ----------------------------------------------------------------------------
interface sgc_out_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                       valid;
    logic                       ready;
    logic [SAMPLE_BITS-1:0]     pixel_out;
    logic [sgc_pkg::CH_W-1:0]   out_channel;

    modport source (
        output valid, pixel_out, out_channel,
        input  ready
    );
    modport sink (
        input  valid, pixel_out, out_channel,
        output ready
    );
endinterface

[sv/segmented_gamma_curve_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_gamma_curve_unit: piecewise linear gamma correction
// Per-channel segment table of offset and slope, fixed breakpoints, rounded
// saturating interpolation, bypass when disabled or for an unknown channel.
//
//   Channel    Dir  Handshake    Payload
//   i_pix      in   valid/ready  cmd, channel, segment_index, offset, slope, pixel
//   o_pix      out  valid/ready  pixel_out, out_channel
//   i_cfg_*    in   write enable curve_enable
//
// One beat per cycle sustained while the output is taken. A pixel goes
// through segment select and table read into the first register, then one
// multiply and add with saturation into the output register. Writes take
// effect on the beat edge and yield no output. Synchronous active-low reset
// clears the enable and the valid flags; the table is undefined until written.
// A stalled output holds the pipe; input ready falls only when both stages
// are full and the output is not taken.
// ----------------------------------------------------------------------------
module segmented_gamma_curve_unit #(
    parameter int NUM_SEGMENTS = 15,
    parameter int NUM_CHANNELS = 3,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    sgc_in_if.sink              i_pix,
    sgc_out_if.source           o_pix
);

    localparam int DEPTH   = NUM_CHANNELS * NUM_SEGMENTS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SEG_W   = $clog2(NUM_SEGMENTS);
    localparam int START_W = SAMPLE_BITS + 1;
    localparam int BP_W    = SAMPLE_BITS + 3;
    localparam int UP_SH   = (SAMPLE_BITS >= sgc_pkg::BP_BITS) ?
                             SAMPLE_BITS - sgc_pkg::BP_BITS : 0;
    localparam int DN_SH   = (SAMPLE_BITS < sgc_pkg::BP_BITS) ?
                             sgc_pkg::BP_BITS - SAMPLE_BITS : 0;
    localparam int PROD_W  = sgc_pkg::COEF_W + SAMPLE_BITS;
    localparam int RND_W   = PROD_W + 1;
    localparam int SUM_W   = RND_W - sgc_pkg::UNITY_SHIFT + 1;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    typedef struct packed {
        logic [sgc_pkg::COEF_W-1:0] offset;
        logic [sgc_pkg::COEF_W-1:0] slope;
    } t_entry;

    // segment start at sample scale; past the list it lies above any sample
    function automatic logic [START_W-1:0] seg_start(input int idx);
        logic [BP_W-1:0] b;
        if (idx >= sgc_pkg::BP_COUNT) begin
            return {1'b1, {SAMPLE_BITS{1'b0}}};
        end
        b = (BP_W'(sgc_pkg::BREAKPOINTS[idx]) << UP_SH) >> DN_SH;
        return b[START_W-1:0];
    endfunction

    t_entry                     mem [DEPTH];
    t_entry                     r_rd_data;
    logic                       r_curve_en;
    logic                       r_s1_valid;
    logic                       r_s1_bypass;
    logic [SAMPLE_BITS-1:0]     r_s1_pix;
    logic [SAMPLE_BITS-1:0]     r_s1_start;
    logic [sgc_pkg::CH_W-1:0]   r_s1_ch;
    logic                       r_out_valid;
    logic [SAMPLE_BITS-1:0]     r_pix_out;
    logic [sgc_pkg::CH_W-1:0]   r_out_ch;

    logic                       s2_free;
    logic                       in_acc;
    logic                       wr_en;
    logic                       rd_en;
    logic                       ch_ok;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;
    logic [SEG_W-1:0]           sel_seg;
    logic [SAMPLE_BITS-1:0]     sel_start;
    logic [START_W-1:0]         cand_start;
    logic [SAMPLE_BITS-1:0]     diff;
    logic [PROD_W-1:0]          prod;
    logic [RND_W-1:0]           rnd;
    logic [SUM_W-1:0]           sum;
    logic [SAMPLE_BITS-1:0]     n_pix_out;

    assign s2_free     = !r_out_valid || o_pix.ready;
    assign i_pix.ready = !r_s1_valid || s2_free;
    assign in_acc      = i_pix.valid && i_pix.ready;
    assign ch_ok       = int'(i_pix.channel) < NUM_CHANNELS;
    assign wr_en       = in_acc && (i_pix.cmd == sgc_pkg::CMD_WRITE) && ch_ok &&
                         (int'(i_pix.segment_index) < NUM_SEGMENTS);
    assign rd_en       = in_acc && (i_pix.cmd == sgc_pkg::CMD_PIXEL);

    // last segment whose start is not above the sample
    always_comb begin
        sel_seg    = '0;
        sel_start  = '0;
        cand_start = '0;
        for (int i = 1; i < NUM_SEGMENTS; i++) begin
            cand_start = seg_start(i);
            if (cand_start <= {1'b0, i_pix.pixel_in}) begin
                sel_seg   = SEG_W'(i);
                sel_start = cand_start[SAMPLE_BITS-1:0];
            end
        end
    end

    always_comb begin
        wr_addr = '0;
        rd_addr = '0;
        if (wr_en) begin
            wr_addr = ADDR_W'(int'(i_pix.channel) * NUM_SEGMENTS +
                              int'(i_pix.segment_index));
        end
        if (ch_ok) begin
            rd_addr = ADDR_W'(int'(i_pix.channel) * NUM_SEGMENTS + int'(sel_seg));
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= '{offset: i_pix.offset_value, slope: i_pix.slope_value};
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_curve_en <= i_cfg_wdata;
        end
    end

    // first stage: hold while the output register is full and not taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_valid <= rd_en;
        end
        if (rd_en) begin
            r_s1_bypass <= !r_curve_en || !ch_ok;
            r_s1_pix    <= i_pix.pixel_in;
            r_s1_start  <= sel_start;
            r_s1_ch     <= i_pix.channel;
        end
    end

    always_comb begin
        diff = r_s1_pix - r_s1_start;
        prod = PROD_W'(r_rd_data.slope) * PROD_W'(diff);
        rnd  = RND_W'(prod) + RND_W'(sgc_pkg::ROUND_HALF);
        sum  = SUM_W'(rnd >> sgc_pkg::UNITY_SHIFT) + SUM_W'(r_rd_data.offset);
        if (r_s1_bypass) begin
            n_pix_out = r_s1_pix;
        end else if (sum > SUM_W'(SAMPLE_MAX)) begin
            n_pix_out = SAMPLE_MAX;
        end else begin
            n_pix_out = sum[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_free) begin
            r_out_valid <= r_s1_valid;
        end
        if (s2_free && r_s1_valid) begin
            r_pix_out <= n_pix_out;
            r_out_ch  <= r_s1_ch;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_out   = r_pix_out;
    assign o_pix.out_channel = r_out_ch;

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_pix.cmd == sgc_pkg::CMD_WRITE) |=> !r_s1_valid)
        else $error("write beat entered the result pipe");

    a_pixel_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_pix.cmd == sgc_pkg::CMD_PIXEL) |=> r_s1_valid)
        else $error("pixel beat lost at the first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_free |=> r_s1_valid && $stable(r_rd_data) && $stable(r_s1_pix))
        else $error("first stage changed while stalled");

    a_bypass_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_bypass && s2_free |=> o_pix.pixel_out == $past(r_s1_pix))
        else $error("bypassed pixel altered");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: segmented gamma curve unit
// Loads the segment tables, runs directed conversions and table writes, then
// random phases with the curve enabled and bypassed. A scoreboard predicts
// every converted beat in order and checks each output beat field by field,
// under random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------

localparam int N_CHANNELS  = 3;
localparam int N_SEGMENTS  = 15;
localparam int SAMPLE_MAX  = 1023;
localparam int PIPE_SETTLE = 4;

typedef struct packed {
    logic       cmd;
    logic [1:0] channel;
    logic [3:0] seg;
    logic [9:0] offset;
    logic [9:0] slope;
    logic [9:0] pixel;
} t_gamma_beat;

typedef struct packed {
    logic [9:0] pixel;
    logic [1:0] channel;
} t_gamma_result;

class gamma_scoreboard;
    logic [9:0]    offset_tbl [N_CHANNELS*N_SEGMENTS];
    logic [9:0]    slope_tbl  [N_CHANNELS*N_SEGMENTS];
    bit            curve_en;
    int            errors;
    t_gamma_result expected_q [$];

    function new();
        curve_en = 1'b0;
        errors   = 0;
    endfunction

    function logic [9:0] corrected(logic [1:0] ch, logic [9:0] pix);
        int seg;
        int start;
        int idx;
        int v;
        seg = 0;
        for (int i = 1; i < N_SEGMENTS; i++) begin
            if (int'(sgc_pkg::BREAKPOINTS[i]) <= int'(pix)) seg = i;
        end
        start = int'(sgc_pkg::BREAKPOINTS[seg]);
        idx   = int'(ch) * N_SEGMENTS + seg;
        v     = int'(offset_tbl[idx]) +
                ((int'(slope_tbl[idx]) * (int'(pix) - start) + sgc_pkg::ROUND_HALF)
                 >> sgc_pkg::UNITY_SHIFT);
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        return v[9:0];
    endfunction

    function void note_beat(t_gamma_beat b);
        int            idx;
        t_gamma_result r;
        if (b.cmd == sgc_pkg::CMD_WRITE) begin
            // drop writes to a channel or segment that does not exist
            if (int'(b.channel) < N_CHANNELS && int'(b.seg) < N_SEGMENTS) begin
                idx = int'(b.channel) * N_SEGMENTS + int'(b.seg);
                offset_tbl[idx] = b.offset;
                slope_tbl[idx]  = b.slope;
            end
        end else begin
            r.channel = b.channel;
            if (curve_en && int'(b.channel) < N_CHANNELS)
                r.pixel = corrected(b.channel, b.pixel);
            else
                r.pixel = b.pixel;
            expected_q.push_back(r);
        end
    endfunction

    function void check_result(logic [9:0] pix, logic [1:0] ch);
        t_gamma_result want;
        if (expected_q.size() == 0) begin
            $error("unexpected beat: pixel_out=%0d out_channel=%0d", pix, ch);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (pix !== want.pixel) begin
            $error("pixel_out: expected %0d, actual %0d", want.pixel, pix);
            errors++;
        end
        if (ch !== want.channel) begin
            $error("out_channel: expected %0d, actual %0d", want.channel, ch);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module testbench;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    sgc_in_if  #(.SAMPLE_BITS(10)) pix_in_if ();
    sgc_out_if #(.SAMPLE_BITS(10)) pix_out_if ();

    segmented_gamma_curve_unit #(
        .NUM_SEGMENTS(N_SEGMENTS),
        .NUM_CHANNELS(N_CHANNELS),
        .SAMPLE_BITS (10)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_pix      (pix_in_if),
        .o_pix      (pix_out_if)
    );

    gamma_scoreboard gamma_sb = new();

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int hold_req   = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // output side: check taken beats, then choose ready for the next cycle
    initial begin : rx_proc
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        pix_out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pix_out_if.valid && pix_out_if.ready)
                gamma_sb.check_result(pix_out_if.pixel_out, pix_out_if.out_channel);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                pix_out_if.ready <= 1'b0;
            end else begin
                pix_out_if.ready <= !rx_idle_en || ($urandom_range(0, 99) >= 12);
            end
        end
    end

    task automatic push_beat(t_gamma_beat b);
        if (tx_idle_en && $urandom_range(0, 99) < 12) begin
            pix_in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in_if.valid         <= 1'b1;
        pix_in_if.cmd           <= b.cmd;
        pix_in_if.channel       <= b.channel;
        pix_in_if.segment_index <= b.seg;
        pix_in_if.offset_value  <= b.offset;
        pix_in_if.slope_value   <= b.slope;
        pix_in_if.pixel_in      <= b.pixel;
        @(posedge i_clk);
        while (!(pix_in_if.valid && pix_in_if.ready)) @(posedge i_clk);
        gamma_sb.note_beat(b);
    endtask

    // hold the input until every predicted beat is out and the pipe is empty
    task automatic drain_results();
        pix_in_if.valid <= 1'b0;
        while (gamma_sb.pending() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic set_curve_enable(bit v);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        gamma_sb.curve_en = v;
    endtask

    function automatic t_gamma_beat make_write(int ch, int seg, int off, int slope);
        t_gamma_beat b;
        b.cmd     = sgc_pkg::CMD_WRITE;
        b.channel = 2'(ch);
        b.seg     = 4'(seg);
        b.offset  = 10'(off);
        b.slope   = 10'(slope);
        b.pixel   = 10'($urandom_range(0, 1023));
        return b;
    endfunction

    function automatic t_gamma_beat make_pixel(int ch, int pix);
        t_gamma_beat b;
        b.cmd     = sgc_pkg::CMD_PIXEL;
        b.channel = 2'(ch);
        b.seg     = 4'($urandom_range(0, 15));
        b.offset  = 10'($urandom_range(0, 1023));
        b.slope   = 10'($urandom_range(0, 1023));
        b.pixel   = 10'(pix);
        return b;
    endfunction

    // uniform samples, samples inside one segment, and segment edges
    function automatic int random_pixel();
        int r;
        int s;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, 13);
        if (r < 40) return $urandom_range(0, 1023);
        if (r < 85) return $urandom_range(int'(sgc_pkg::BREAKPOINTS[s]),
                                          int'(sgc_pkg::BREAKPOINTS[s+1]) - 1);
        if (r < 92) return int'(sgc_pkg::BREAKPOINTS[s]);
        return int'(sgc_pkg::BREAKPOINTS[s+1]);
    endfunction

    function automatic t_gamma_beat random_beat();
        int ch;
        int seg;
        int slope;
        ch = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2);
        if ($urandom_range(0, 99) < 15) begin
            seg   = ($urandom_range(0, 19) == 0) ? 15 : $urandom_range(0, 14);
            slope = $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(32, 96);
            return make_write(ch, seg, $urandom_range(0, 1023), slope);
        end
        return make_pixel(ch, random_pixel());
    endfunction

    initial begin
        i_rst_n                 <= 1'b0;
        i_cfg_we                <= 1'b0;
        i_cfg_wdata             <= 1'b0;
        pix_in_if.valid         <= 1'b0;
        pix_in_if.cmd           <= sgc_pkg::CMD_PIXEL;
        pix_in_if.channel       <= '0;
        pix_in_if.segment_index <= '0;
        pix_in_if.offset_value  <= '0;
        pix_in_if.slope_value   <= '0;
        pix_in_if.pixel_in      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every entry: red is the identity curve, the others random
        for (int ch = 0; ch < N_CHANNELS; ch++) begin
            for (int seg = 0; seg < N_SEGMENTS; seg++) begin
                if (ch == 0)
                    push_beat(make_write(ch, seg, int'(sgc_pkg::BREAKPOINTS[seg]), 64));
                else
                    push_beat(make_write(ch, seg, $urandom_range(0, 1023),
                                         $urandom_range(0, 1023)));
            end
        end
        set_curve_enable(1'b1);

        push_beat(make_pixel(0, 0));
        push_beat(make_pixel(0, 1023));
        push_beat(make_pixel(0, 15));
        push_beat(make_pixel(0, 16));
        push_beat(make_pixel(0, 896));
        push_beat(make_pixel(3, 777));
        // writes to a missing channel or segment must leave red untouched
        push_beat(make_write(3, 0, 5, 0));
        push_beat(make_write(0, 15, 1023, 1023));
        push_beat(make_pixel(0, 5));
        push_beat(make_write(1, 13, 1023, 1023));
        push_beat(make_pixel(1, 1000));
        push_beat(make_pixel(1, 1022));
        push_beat(make_write(2, 0, 0, 0));
        push_beat(make_pixel(2, 15));
        push_beat(make_write(2, 14, 1023, 0));
        push_beat(make_pixel(2, 1023));
        // rounding edge: slope of one over a half step either side
        push_beat(make_write(1, 5, 300, 1));
        push_beat(make_pixel(1, 160));
        push_beat(make_pixel(1, 159));
        push_beat(make_write(0, 7, 0, 1023));
        push_beat(make_pixel(0, 319));
        set_curve_enable(1'b0);
        push_beat(make_pixel(1, 1023));
        push_beat(make_pixel(2, 0));
        push_beat(make_pixel(3, 512));

        for (int phase = 0; phase < 6; phase++) begin
            set_curve_enable(phase != 1 && phase != 4);
            tx_idle_en = (phase != 2);
            rx_idle_en = (phase != 2);
            if (phase == 3) begin
                // stall the output long enough to fill the pipe and back up the input
                tx_idle_en = 1'b0;
                hold_req++;
            end
            for (int n = 0; n < 114; n++) begin
                if (phase == 3 && n == 60) tx_idle_en = 1'b1;
                if ((phase == 4 || phase == 5) && n == 60) drain_results();
                push_beat(random_beat());
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        drain_results();
        if (gamma_sb.errors == 0 && gamma_sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
sv/sgc_pkg.sv
sv/sgc_in_if.sv
sv/sgc_out_if.sv
sv/segmented_gamma_curve_unit.sv
bench/testbench.sv
